// File: src/assert_macros.svh
// Assertion macros shared by the sync/escape frame receiver modules.
// Each macro takes label, clock, synchronous reset, expression and message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define SEFR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition is never true outside reset.
`define SEFR_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: src/sefr_pkg.sv
// Package of the sync/escape frame receiver: types, codes and constants.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sefr_pkg;

  localparam logic [7:0] SYNC_BYTE   = 8'hE0;
  localparam logic [7:0] ESC_BYTE    = 8'hD0;
  localparam logic [3:0] LIMIT_RESET = 4'd3;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_ADDR = 2'd1,
    PH_LEN  = 2'd2,
    PH_BODY = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_BYTE    = 3'd0,
    ST_GOOD    = 3'd1,
    ST_CKERR   = 3'd2,
    ST_TIMEOUT = 3'd3,
    ST_ZEROLEN = 3'd4
  } status_t;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_IDLE = 1'b1
  } command_t;

  // A classified request as it travels from the front end to the back end.
  typedef struct packed {
    command_t   cmd;
    logic [7:0] raw;
    logic       is_sync;
    logic       is_esc;
  } item_t;

endpackage

`default_nettype wire

// File: src/sefr_front.sv
// Front end of the frame receiver: takes input requests and classifies them.
// Depends on sefr_pkg; feeds sefr_queue.
`default_nettype none

module sefr_front (
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [7:0]      s_tdata,
  input  wire logic            s_tuser,
  input  wire logic            queue_full,
  output logic                 push,
  output sefr_pkg::item_t      push_item
);

  assign s_tready = !queue_full;
  assign push     = s_tvalid && !queue_full;

  always_comb begin
    push_item.cmd     = sefr_pkg::command_t'(s_tuser);
    push_item.raw     = s_tdata;
    push_item.is_sync = (s_tuser == sefr_pkg::CMD_BYTE) && (s_tdata == sefr_pkg::SYNC_BYTE);
    push_item.is_esc  = (s_tuser == sefr_pkg::CMD_BYTE) && (s_tdata == sefr_pkg::ESC_BYTE);
  end

endmodule

`default_nettype wire

// File: src/sefr_queue.sv
// Short register queue between the front end and the back end.
// Depends on sefr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sefr_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire sefr_pkg::item_t push_item,
  input  wire logic            pop,
  output logic                 full,
  output logic                 not_empty,
  output sefr_pkg::item_t      head
);

  localparam int unsigned PW = sefr_pkg::QUEUE_PTR_W;
  localparam int unsigned CW = sefr_pkg::QUEUE_CNT_W;

  sefr_pkg::item_t entries [sefr_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full      = (count == CW'(sefr_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `SEFR_NEVER(a_no_push_full, clk, rst, push && full, "push into a full queue")
  `SEFR_NEVER(a_no_pop_empty, clk, rst, pop && !not_empty, "pop from an empty queue")
  `SEFR_ASSERT(a_count_bound, clk, rst, count <= CW'(sefr_pkg::QUEUE_DEPTH), "queue overflow")

endmodule

`default_nettype wire

// File: src/sefr_back.sv
// Back end of the frame receiver: frame state, checksum, timeout and result register.
// Depends on sefr_pkg and assert_macros.svh; reads from sefr_queue.
`default_nettype none
`include "assert_macros.svh"

module sefr_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [3:0]      cfg_data,
  input  wire logic            not_empty,
  input  wire sefr_pkg::item_t head,
  output logic                 pop,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [23:0]          m_tdata,
  output logic                 m_tlast,
  output logic [2:0]           m_tuser
);

  logic [3:0]       idle_poll_limit;
  sefr_pkg::phase_t phase;
  sefr_pkg::phase_t phase_next;
  logic             escape_pending;
  logic             escape_pending_next;
  logic [7:0]       running_sum;
  logic [7:0]       running_sum_next;
  logic [7:0]       frame_length;
  logic [7:0]       frame_length_next;
  logic [8:0]       position;
  logic [8:0]       position_next;
  logic [3:0]       idle_count;
  logic [3:0]       idle_count_next;

  logic              out_valid;
  logic [7:0]        out_byte;
  logic [8:0]        out_index;
  logic              out_last;
  sefr_pkg::status_t out_status;

  logic              emit;
  logic [7:0]        emit_byte;
  logic [8:0]        emit_index;
  logic              emit_last;
  sefr_pkg::status_t emit_status;
  logic [7:0]        value;

  assign pop = not_empty && (!out_valid || m_tready);

  always_comb begin
    phase_next          = phase;
    escape_pending_next = escape_pending;
    running_sum_next    = running_sum;
    frame_length_next   = frame_length;
    position_next       = position;
    idle_count_next     = idle_count;
    emit                = 1'b0;
    emit_byte           = '0;
    emit_index          = '0;
    emit_last           = 1'b0;
    emit_status         = sefr_pkg::ST_BYTE;
    value               = escape_pending ? (head.raw + 8'd1) : head.raw;

    if (head.cmd == sefr_pkg::CMD_IDLE) begin
      if (phase == sefr_pkg::PH_HUNT) begin
        idle_count_next = idle_poll_limit;
      end else if (idle_count <= 4'd1) begin
        emit                = 1'b1;
        emit_index          = position;
        emit_last           = 1'b1;
        emit_status         = sefr_pkg::ST_TIMEOUT;
        phase_next          = sefr_pkg::PH_HUNT;
        escape_pending_next = 1'b0;
        idle_count_next     = idle_poll_limit;
      end else begin
        idle_count_next = idle_count - 4'd1;
      end
    end else begin
      idle_count_next = idle_poll_limit;
      if (!escape_pending && head.is_sync) begin
        phase_next        = sefr_pkg::PH_ADDR;
        running_sum_next  = '0;
        frame_length_next = '0;
        position_next     = 9'd1;
        emit              = 1'b1;
        emit_byte         = sefr_pkg::SYNC_BYTE;
      end else if (phase == sefr_pkg::PH_HUNT) begin
        emit = 1'b0;
      end else if (!escape_pending && head.is_esc) begin
        escape_pending_next = 1'b1;
      end else begin
        escape_pending_next = 1'b0;
        emit                = 1'b1;
        emit_byte           = value;
        unique case (phase)
          sefr_pkg::PH_ADDR: begin
            running_sum_next = value;
            phase_next       = sefr_pkg::PH_LEN;
            position_next    = 9'd2;
            emit_index       = 9'd1;
          end
          sefr_pkg::PH_LEN: begin
            frame_length_next = value;
            running_sum_next  = running_sum + value;
            emit_index        = 9'd2;
            if (value == 8'd0) begin
              emit_last       = 1'b1;
              emit_status     = sefr_pkg::ST_ZEROLEN;
              phase_next      = sefr_pkg::PH_HUNT;
              idle_count_next = idle_poll_limit;
            end else begin
              phase_next    = sefr_pkg::PH_BODY;
              position_next = 9'd3;
            end
          end
          sefr_pkg::PH_BODY: begin
            emit_index = position;
            if (position >= ({1'b0, frame_length} + 9'd2)) begin
              emit_last       = 1'b1;
              emit_status     = (value == running_sum) ? sefr_pkg::ST_GOOD
                                                       : sefr_pkg::ST_CKERR;
              phase_next      = sefr_pkg::PH_HUNT;
              idle_count_next = idle_poll_limit;
            end else begin
              running_sum_next = running_sum + value;
              position_next    = position + 9'd1;
            end
          end
          default: begin
            emit = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_poll_limit <= sefr_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      idle_poll_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= sefr_pkg::PH_HUNT;
      escape_pending <= 1'b0;
      running_sum    <= '0;
      frame_length   <= '0;
      position       <= '0;
      idle_count     <= sefr_pkg::LIMIT_RESET;
    end else if (pop) begin
      phase          <= phase_next;
      escape_pending <= escape_pending_next;
      running_sum    <= running_sum_next;
      frame_length   <= frame_length_next;
      position       <= position_next;
      idle_count     <= idle_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= emit;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_byte   <= emit_byte;
      out_index  <= emit_index;
      out_last   <= emit_last;
      out_status <= emit_status;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_index, out_byte};
  assign m_tlast  = out_last;
  assign m_tuser  = out_status;

  `SEFR_NEVER(a_no_escape_hunting, clk, rst,
    escape_pending && (phase == sefr_pkg::PH_HUNT), "escape pending while hunting")
  `SEFR_ASSERT(a_error_is_last, clk, rst,
    m_tvalid && (m_tuser != sefr_pkg::ST_BYTE) |-> m_tlast, "frame end without last")
  `SEFR_ASSERT(a_end_to_hunt, clk, rst,
    pop && emit && emit_last |=> phase == sefr_pkg::PH_HUNT, "frame end did not return to hunt")

endmodule

`default_nettype wire

// File: src/sync_escape_frame_receiver_core.sv
// Top level of the sync/escape frame receiver.
// Depends on sefr_pkg, sefr_front, sefr_queue and sefr_back.
//
// Input channel (s_*): one request per received byte (s_tuser = 0, byte in
// s_tdata) or per idle poll period (s_tuser = 1). Output channel (m_*): one
// result for every stored frame byte, carrying the unescaped byte and its
// index in m_tdata, the status code in m_tuser, and m_tlast on the last result
// of a frame or on an error. Escape markers give no result, polls only on timeout.
// The idle poll limit is written through cfg_we and cfg_data; the user must
// write it only while idle, as the block itself does not enforce this. Each
// accepted request is stored in the queue, and the result register loads when
// the back end pops it. Throughput is one request per cycle while the result
// register is empty or m_tready is high.
// When the receiver stalls, a four-entry queue keeps taking requests until it
// fills, and then s_tready drops. Reset empties the queue and the result
// register, returns to hunting for sync and restores the idle poll limit to 3.
`default_nettype none

module sync_escape_frame_receiver_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic        s_tuser,   // [0] command
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [7:0] frame_byte, [16:8] byte_index, rest zero
  output logic             m_tlast,
  output logic [2:0]       m_tuser    // [2:0] status
);

  logic            push;
  sefr_pkg::item_t push_item;
  logic            queue_full;
  logic            queue_not_empty;
  sefr_pkg::item_t queue_head;
  logic            pop;

  sefr_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  sefr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .head      (queue_head)
  );

  sefr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .not_empty (queue_not_empty),
    .head      (queue_head),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

`default_nettype wire
